[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[sv/ccfr_pkg.sv]
// Types, codes and constants of the COBS/CRC frame receiver.
// No dependencies.
`timescale 1ns / 1ps
package ccfr_pkg;

    localparam int RAW_CAPACITY_DEF     = 128;
    localparam int DECODED_CAPACITY_DEF = 128;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0] MIN_FRAME = 8'd6;
    localparam logic [7:0] HDR_BYTES = 8'd4;

    localparam logic CMD_LINE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] KIND_GOOD = 2'd0;
    localparam logic [1:0] KIND_BAD  = 2'd1;
    localparam logic [1:0] KIND_CRC  = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic       command;
        logic [7:0] line_byte;
        logic [6:0] read_index;
    } ccfr_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_type;
        logic [7:0]  version;
        logic [15:0] seq;
        logic [6:0]  payload_len;
        logic [7:0]  read_data;
        logic [31:0] good_count;
        logic [31:0] bad_count;
        logic [31:0] crc_err_count;
    } ccfr_out_t;

    // One decoded action. pos is the store index of a put, the decoded
    // length at a frame end, or the store address of a read. flag marks
    // a bad frame at an end and an in-range index at a read.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] pos;
        logic       flag;
    } ccfr_op_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/ccfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ccfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

[sv/ccfr_front.sv]
// Front end: takes input words, runs the COBS decode state and emits ops.
// Depends on ccfr_pkg.
`timescale 1ns / 1ps
module ccfr_front #(
    parameter int RAW_CAPACITY     = ccfr_pkg::RAW_CAPACITY_DEF,
    parameter int DECODED_CAPACITY = ccfr_pkg::DECODED_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ccfr_pkg::ccfr_in_t word,
    output logic              push,
    output ccfr_pkg::ccfr_op_t push_op
);
    import ccfr_pkg::*;

    logic [7:0] raw_reg, raw_next;
    logic       ovf_reg, ovf_next;
    logic [7:0] bl_reg, bl_next;
    logic       pcf_reg, pcf_next;
    logic       de_reg, de_next;
    logic [7:0] dc_reg, dc_next;

    always_comb
    begin
        logic       put;
        logic [7:0] put_val;
        raw_next = raw_reg;
        ovf_next = ovf_reg;
        bl_next  = bl_reg;
        pcf_next = pcf_reg;
        de_next  = de_reg;
        dc_next  = dc_reg;
        push     = 1'b0;
        push_op  = '0;
        put      = 1'b0;
        put_val  = 8'h00;
        if (accept) begin
            if (word.command == CMD_READ) begin
                push         = 1'b1;
                push_op.op   = OP_READ;
                push_op.pos  = {1'b0, word.read_index} + HDR_BYTES;
                push_op.flag = (dc_reg >= MIN_FRAME) &&
                               ({1'b0, word.read_index} < (dc_reg - MIN_FRAME));
            end else if (word.line_byte != 8'h00) begin
                // The first byte of a frame restarts the decoder.
                if (raw_reg == 8'd0) begin
                    dc_next  = 8'd0;
                    bl_next  = 8'd0;
                    pcf_next = 1'b0;
                    de_next  = 1'b0;
                end
                if (raw_reg < 8'(RAW_CAPACITY)) begin
                    raw_next = raw_reg + 8'd1;
                    if (bl_next == 8'd0) begin
                        // Code byte: a zero is owed unless the last code was full.
                        put      = (raw_reg != 8'd0) && !pcf_next;
                        bl_next  = word.line_byte - 8'd1;
                        pcf_next = (word.line_byte == 8'hFF);
                    end else begin
                        put     = 1'b1;
                        put_val = word.line_byte;
                        bl_next = bl_next - 8'd1;
                    end
                    if (put) begin
                        if (dc_next >= 8'(DECODED_CAPACITY)) begin
                            de_next = 1'b1;
                        end else begin
                            push         = 1'b1;
                            push_op.op   = OP_PUT;
                            push_op.data = put_val;
                            push_op.pos  = dc_next;
                            dc_next      = dc_next + 8'd1;
                        end
                    end
                end else begin
                    ovf_next = 1'b1;
                end
            end else begin
                raw_next = 8'd0;
                ovf_next = 1'b0;
                if (raw_reg != 8'd0) begin
                    push         = 1'b1;
                    push_op.op   = OP_END;
                    push_op.pos  = dc_reg;
                    push_op.flag = ovf_reg || de_reg || (bl_reg != 8'd0) ||
                                   (dc_reg < MIN_FRAME);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            raw_reg <= '0;
            ovf_reg <= 1'b0;
            bl_reg  <= '0;
            pcf_reg <= 1'b0;
            de_reg  <= 1'b0;
            dc_reg  <= '0;
        end else begin
            raw_reg <= raw_next;
            ovf_reg <= ovf_next;
            bl_reg  <= bl_next;
            pcf_reg <= pcf_next;
            de_reg  <= de_next;
            dc_reg  <= dc_next;
        end
    end
endmodule

[sv/ccfr_queue.sv]
// Short op queue between the front end and the back end.
// Depends on ccfr_pkg.
`timescale 1ns / 1ps
module ccfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ccfr_pkg::ccfr_op_t push_op,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output ccfr_pkg::ccfr_op_t head_op
);
    import ccfr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    ccfr_op_t      slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[sv/ccfr_back.sv]
// Back end: frame store, running CRC, header capture, counters and result
// registers. Depends on ccfr_pkg and ccfr_ram.
`timescale 1ns / 1ps
module ccfr_back #(
    parameter int DECODED_CAPACITY = ccfr_pkg::DECODED_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  ccfr_pkg::ccfr_op_t  head_op,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output ccfr_pkg::ccfr_out_t res_word
);
    import ccfr_pkg::*;

    localparam int AW = $clog2(DECODED_CAPACITY);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  b0_reg, b0_next, b1_reg, b1_next;
    logic [7:0]  hdr_reg [4];
    logic [31:0] good_reg, good_next, bad_reg, bad_next, crcerr_reg, crcerr_next;
    logic        s2_valid_reg, s2_valid_next;
    ccfr_out_t   s2_word_reg, s2_word_next;
    logic        s2_rd_reg, s2_rd_next;
    logic        out_valid_reg, out_valid_next;
    ccfr_out_t   out_word_reg, out_word_next;
    logic        out_take, s2_free;
    logic        ram_we, ram_re;
    logic [7:0]  ram_rdata;

    assign out_take  = !out_valid_reg || res_ready;
    assign s2_free   = !s2_valid_reg || out_take;
    assign pop       = head_valid && ((head_op.op == OP_PUT) || s2_free);
    assign ram_we    = pop && (head_op.op == OP_PUT);
    assign ram_re    = pop && (head_op.op == OP_READ);
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    ccfr_ram #(.WIDTH(8), .DEPTH(DECODED_CAPACITY)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_op.pos[AW-1:0]),
        .wdata (head_op.data),
        .re    (ram_re),
        .raddr (head_op.pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        crc_next      = crc_reg;
        b0_next       = b0_reg;
        b1_next       = b1_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        crcerr_next   = crcerr_reg;
        s2_valid_next = s2_free ? 1'b0 : s2_valid_reg;
        s2_word_next  = s2_word_reg;
        s2_rd_next    = s2_rd_reg;
        if (pop) begin
            case (head_op.op)
                OP_PUT:
                begin
                    // The CRC trails by two bytes so that the check bytes stay out.
                    if (head_op.pos >= 8'd2)
                        crc_next = crc16_byte(crc_reg, b1_reg);
                    b1_next = b0_reg;
                    b0_next = head_op.data;
                end
                OP_END:
                begin
                    s2_valid_next = 1'b1;
                    s2_word_next  = '0;
                    s2_rd_next    = 1'b0;
                    crc_next      = CRC_INIT;
                    if (head_op.flag) begin
                        bad_next          = bad_reg + 32'd1;
                        s2_word_next.kind = KIND_BAD;
                    end else if (crc_reg != {b0_reg, b1_reg}) begin
                        crcerr_next       = crcerr_reg + 32'd1;
                        s2_word_next.kind = KIND_CRC;
                    end else begin
                        good_next                = good_reg + 32'd1;
                        s2_word_next.kind        = KIND_GOOD;
                        s2_word_next.msg_type    = hdr_reg[0];
                        s2_word_next.version     = hdr_reg[1];
                        s2_word_next.seq         = {hdr_reg[3], hdr_reg[2]};
                        s2_word_next.payload_len = 7'(head_op.pos - MIN_FRAME);
                    end
                end
                OP_READ:
                begin
                    s2_valid_next     = 1'b1;
                    s2_word_next      = '0;
                    s2_word_next.kind = KIND_READ;
                    s2_rd_next        = head_op.flag;
                end
                default:
                begin
                    s2_valid_next = s2_valid_reg;
                end
            endcase
            s2_word_next.good_count    = good_next;
            s2_word_next.bad_count     = bad_next;
            s2_word_next.crc_err_count = crcerr_next;
        end
        out_valid_next = out_take ? s2_valid_reg : out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_take) begin
            out_word_next = s2_word_reg;
            // Read data leaves the store in the cycle after the address.
            if (s2_rd_reg)
                out_word_next.read_data = ram_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we && (head_op.pos < 8'd4))
            hdr_reg[head_op.pos[1:0]] <= head_op.data;
        b0_reg       <= b0_next;
        b1_reg       <= b1_next;
        s2_word_reg  <= s2_word_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= CRC_INIT;
            good_reg      <= '0;
            bad_reg       <= '0;
            crcerr_reg    <= '0;
            s2_valid_reg  <= 1'b0;
            s2_rd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            crcerr_reg    <= crcerr_next;
            s2_valid_reg  <= s2_valid_next;
            s2_rd_reg     <= s2_rd_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[sv/cobs_crc_frame_receiver_core.sv]
// COBS frame receiver with CRC-16 check: usage notes.
// Input channel line_valid/line_ready/line_word: one word per line byte
// (command line) or per payload read (command read). A zero line byte ends
// a frame. Output channel res_valid/res_ready/res_word: one status word per
// non-empty frame (good, bad, crc error) and one word per read.
// One input word is taken every cycle while the op queue has room; the
// back end retires one op per cycle while ends and reads find the next
// stage free, so the sustained rate is one word per cycle while results
// are taken. A result passes the op queue, the store/CRC stage and the
// output register, where read data from the store joins it, to res_valid.
// When the receiver holds res_ready low, results wait in the output
// register and the stage before it, and the four-entry op queue absorbs
// further words before line_ready falls; line bytes that give no result
// keep flowing as long as the queue drains.
// Reset clears decoder state, CRC, counters and all valid flags; the
// frame store is not cleared, and only bytes of the current frame are read.
// Depends on ccfr_pkg, ccfr_front, ccfr_queue and ccfr_back.
`timescale 1ns / 1ps
module cobs_crc_frame_receiver_core #(
    parameter int RAW_CAPACITY     = ccfr_pkg::RAW_CAPACITY_DEF,
    parameter int DECODED_CAPACITY = ccfr_pkg::DECODED_CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               line_valid,
    output logic               line_ready,
    input  ccfr_pkg::ccfr_in_t  line_word,
    output logic               res_valid,
    input  logic               res_ready,
    output ccfr_pkg::ccfr_out_t res_word
);
    import ccfr_pkg::*;

    logic     push, full, pop, head_valid;
    ccfr_op_t push_op, head_op;

    assign line_ready = !full;

    ccfr_front #(
        .RAW_CAPACITY     (RAW_CAPACITY),
        .DECODED_CAPACITY (DECODED_CAPACITY)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (line_valid && line_ready),
        .word    (line_word),
        .push    (push),
        .push_op (push_op)
    );

    ccfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    ccfr_back #(
        .DECODED_CAPACITY (DECODED_CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_word   (res_word)
    );
endmodule

[sv/ccfr_checker.sv]
// Port-level checks of the frame receiver, bound to the top level.
// Depends on ccfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               line_valid,
    input logic               line_ready,
    input ccfr_pkg::ccfr_in_t  line_word,
    input logic               res_valid,
    input logic               res_ready,
    input ccfr_pkg::ccfr_out_t res_word
);
    import ccfr_pkg::*;

    logic res_stall;
    logic line_stall;
    logic read_shown;
    logic status_shown;
    logic hdr_clear;

    assign res_stall    = res_valid && !res_ready;
    assign line_stall   = line_valid && !line_ready;
    assign read_shown   = res_valid && (res_word.kind == KIND_READ);
    assign status_shown = res_valid && (res_word.kind != KIND_READ);
    assign hdr_clear    = (res_word.msg_type == 8'h00) && (res_word.version == 8'h00) &&
                          (res_word.seq == 16'h0000) && (res_word.payload_len == 7'd0);

    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid && $stable(res_word))
    `ASSERT_NEXT(a_line_hold, clk, rst_n, line_stall, line_valid && $stable(line_word))
    `ASSERT_ALWAYS(a_no_res_in_reset, clk, !rst_n, !res_valid)
    `ASSERT_IMPLY(a_read_no_header, clk, rst_n, read_shown, hdr_clear)
    `ASSERT_IMPLY(a_status_no_data, clk, rst_n, status_shown, res_word.read_data == 8'h00)
endmodule

bind cobs_crc_frame_receiver_core ccfr_checker u_ccfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_word  (line_word),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word)
);

[bench/tb.sv]
// Self-checking bench for cobs_crc_frame_receiver_core: COBS frames, CRC checks
// and payload reads are predicted here and compared word by word at the output.
// Depends on ccfr_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
    import ccfr_pkg::*;

    localparam int RAW_CAP   = 128;
    localparam int DEC_CAP   = 128;
    localparam int LIMIT     = 600000;
    localparam int DRAIN     = 20;

    typedef enum int {FR_GOOD, FR_CRC, FR_TRUNC, FR_SHORT, FR_RAW_OVF} frame_mode_t;

    logic       clk;
    logic       rst_n;
    logic       line_valid;
    logic       line_ready;
    ccfr_in_t   line_word;
    logic       res_valid;
    logic       res_ready;
    ccfr_out_t  res_word;

    cobs_crc_frame_receiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_valid(line_valid),
        .line_ready(line_ready),
        .line_word (line_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Words waiting to be offered, and status/read words still to come out.
    ccfr_in_t  pending_words[$];
    ccfr_out_t expected_words[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_served = 0;
    int hold_left = 0;
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int frames_crc = 0;
    int reads_seen = 0;
    longint cycles = 0;

    // Receiver state as the block should hold it.
    int          rx_raw_count;
    bit          rx_raw_ovf;
    int          rx_block_left;
    bit          rx_prev_full;
    bit          rx_dec_err;
    int          rx_dec_count;
    logic [7:0]  rx_store[DEC_CAP];
    logic [31:0] cnt_good;
    logic [31:0] cnt_bad;
    logic [31:0] cnt_crc;

    function automatic logic [15:0] crc_ccitt(input logic [7:0] data[$], input int len);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < len; i++)
        begin
            c = c ^ {data[i], 8'h00};
            for (int k = 0; k < 8; k++)
                c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic store_decoded(input logic [7:0] v);
        if (rx_dec_count >= DEC_CAP)
            rx_dec_err = 1'b1;
        else
        begin
            rx_store[rx_dec_count] = v;
            rx_dec_count++;
        end
    endtask

    task automatic predict_word(input ccfr_in_t w);
        ccfr_out_t   r;
        logic [7:0]  frame[$];
        logic [15:0] want;
        int          n;
        r = '0;
        if (w.command == CMD_READ)
        begin
            if (rx_dec_count >= 6 && int'(w.read_index) < rx_dec_count - 6)
                r.read_data = rx_store[4 + w.read_index];
            r.kind = KIND_READ;
        end
        else if (w.line_byte != 8'h00)
        begin
            if (rx_raw_count == 0)
            begin
                rx_dec_count = 0;
                rx_block_left = 0;
                rx_prev_full = 1'b0;
                rx_dec_err = 1'b0;
            end
            if (rx_raw_count < RAW_CAP)
            begin
                rx_raw_count++;
                if (rx_block_left == 0)
                begin
                    // A code byte owes a zero unless the previous block was full.
                    if (rx_raw_count > 1 && !rx_prev_full)
                        store_decoded(8'h00);
                    rx_block_left = int'(w.line_byte) - 1;
                    rx_prev_full = (w.line_byte == 8'hFF);
                end
                else
                begin
                    store_decoded(w.line_byte);
                    rx_block_left--;
                end
            end
            else
                rx_raw_ovf = 1'b1;
            return;
        end
        else
        begin
            n = rx_raw_count;
            rx_raw_count = 0;
            if (n == 0)
            begin
                rx_raw_ovf = 1'b0;
                return;
            end
            if (rx_raw_ovf || rx_dec_err || rx_block_left != 0 || rx_dec_count < 6)
            begin
                cnt_bad++;
                r.kind = KIND_BAD;
            end
            else
            begin
                for (int i = 0; i < rx_dec_count; i++)
                    frame.push_back(rx_store[i]);
                want = {rx_store[rx_dec_count - 1], rx_store[rx_dec_count - 2]};
                if (crc_ccitt(frame, rx_dec_count - 2) != want)
                begin
                    cnt_crc++;
                    r.kind = KIND_CRC;
                end
                else
                begin
                    cnt_good++;
                    r.kind = KIND_GOOD;
                    r.msg_type = rx_store[0];
                    r.version = rx_store[1];
                    r.seq = {rx_store[3], rx_store[2]};
                    r.payload_len = 7'(rx_dec_count - 6);
                end
            end
            rx_raw_ovf = 1'b0;
        end
        r.good_count = cnt_good;
        r.bad_count = cnt_bad;
        r.crc_err_count = cnt_crc;
        expected_words.push_back(r);
    endtask

    // Sender: offers pending words, holding each until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid <= 1'b0;
            line_word <= '0;
        end
        else
        begin
            if (line_valid && line_ready)
            begin
                predict_word(line_word);
                words_sent++;
            end
            if (!line_valid || line_ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    line_word <= pending_words.pop_front();
                    line_valid <= 1'b1;
                end
                else
                    line_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off: started on request and counted down here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (hold_request != hold_served)
            begin
                hold_served <= hold_request;
                hold_left <= 400;
            end
        end
    end

    // Receiver: random stalls, long hold-offs on request, and the checks.
    always @(posedge clk or negedge rst_n)
    begin
        ccfr_out_t e;
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word, kind %0d", res_word.kind);
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    case (e.kind)
                        KIND_GOOD: frames_good++;
                        KIND_BAD:  frames_bad++;
                        KIND_CRC:  frames_crc++;
                        default:   reads_seen++;
                    endcase
                    if (res_word.kind !== e.kind)
                    begin
                        $error("kind: expected %0d, got %0d", e.kind, res_word.kind);
                        errors++;
                    end
                    if (res_word.msg_type !== e.msg_type)
                    begin
                        $error("msg_type: expected %0h, got %0h", e.msg_type, res_word.msg_type);
                        errors++;
                    end
                    if (res_word.version !== e.version)
                    begin
                        $error("version: expected %0h, got %0h", e.version, res_word.version);
                        errors++;
                    end
                    if (res_word.seq !== e.seq)
                    begin
                        $error("seq: expected %0h, got %0h", e.seq, res_word.seq);
                        errors++;
                    end
                    if (res_word.payload_len !== e.payload_len)
                    begin
                        $error("payload_len: expected %0d, got %0d", e.payload_len,
                               res_word.payload_len);
                        errors++;
                    end
                    if (res_word.read_data !== e.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h", e.read_data,
                               res_word.read_data);
                        errors++;
                    end
                    if (res_word.good_count !== e.good_count)
                    begin
                        $error("good_count: expected %0d, got %0d", e.good_count,
                               res_word.good_count);
                        errors++;
                    end
                    if (res_word.bad_count !== e.bad_count)
                    begin
                        $error("bad_count: expected %0d, got %0d", e.bad_count,
                               res_word.bad_count);
                        errors++;
                    end
                    if (res_word.crc_err_count !== e.crc_err_count)
                    begin
                        $error("crc_err_count: expected %0d, got %0d", e.crc_err_count,
                               res_word.crc_err_count);
                        errors++;
                    end
                end
            end
            if (hold_left > 0 || hold_request != hold_served)
                res_ready <= 1'b0;
            else
                res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_line(input logic [7:0] b);
        ccfr_in_t w;
        w.command = CMD_LINE;
        w.line_byte = b;
        w.read_index = 7'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic push_read(input logic [6:0] idx);
        ccfr_in_t w;
        w.command = CMD_READ;
        w.line_byte = 8'($urandom);
        w.read_index = idx;
        pending_words.push_back(w);
    endtask

    // COBS-encodes a decoded frame and sends it followed by the delimiter.
    task automatic send_encoded(input logic [7:0] data[$]);
        logic [7:0] enc[$];
        int code_pos;
        int code;
        enc.push_back(8'h00);
        code_pos = 0;
        code = 1;
        foreach (data[i])
        begin
            if (data[i] == 8'h00)
            begin
                enc[code_pos] = 8'(code);
                code_pos = enc.size();
                enc.push_back(8'h00);
                code = 1;
            end
            else
            begin
                enc.push_back(data[i]);
                code++;
                if (code == 255)
                begin
                    enc[code_pos] = 8'hFF;
                    code_pos = enc.size();
                    enc.push_back(8'h00);
                    code = 1;
                end
            end
        end
        enc[code_pos] = 8'(code);
        foreach (enc[i])
            push_line(enc[i]);
        push_line(8'h00);
    endtask

    task automatic send_frame(input frame_mode_t mode, input int plen, input int zero_pct);
        logic [7:0]  data[$];
        logic [15:0] c;
        int          n;
        if (mode == FR_SHORT)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
                data.push_back(8'($urandom));
            send_encoded(data);
            return;
        end
        if (mode == FR_RAW_OVF)
        begin
            push_line(8'hFF);
            repeat (RAW_CAP + $urandom_range(1, 10))
                push_line(8'($urandom_range(1, 255)));
            push_line(8'h00);
            return;
        end
        repeat (4 + plen)
            data.push_back($urandom_range(99) < zero_pct ? 8'h00 : 8'($urandom));
        c = crc_ccitt(data, data.size());
        if (mode == FR_CRC)
            c = c ^ (16'h1 << $urandom_range(15));
        data.push_back(c[7:0]);
        data.push_back(c[15:8]);
        if (mode == FR_TRUNC)
        begin
            // Drop the tail and end on a block that promises more bytes.
            foreach (data[i])
                if (data[i] == 8'h00)
                    data[i] = 8'h5A;
            push_line(8'(data.size() + 1));
            for (int i = 0; i < data.size() - $urandom_range(1, 3); i++)
                push_line(data[i]);
            push_line(8'h00);
            return;
        end
        send_encoded(data);
    endtask

    task automatic random_unit();
        int pick;
        int plen;
        pick = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 16);
        if (pick < 55)
            send_frame(FR_GOOD, plen, 15);
        else if (pick < 65)
            send_frame(FR_CRC, plen, 15);
        else if (pick < 80)
            repeat ($urandom_range(1, 4))
                push_read($urandom_range(1) ? 7'($urandom_range(0, 20)) : 7'($urandom));
        else if (pick < 86)
            send_frame(FR_TRUNC, $urandom_range(0, 10), 0);
        else if (pick < 91)
            send_frame(FR_SHORT, 0, 0);
        else if (pick < 93)
            send_frame(FR_RAW_OVF, 0, 0);
        else
            repeat ($urandom_range(1, 8))
                push_line($urandom_range(3) == 0 ? 8'h00 : 8'($urandom));
    endtask

    task automatic wait_quiet();
        while (pending_words.size() > 0 || line_valid || expected_words.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int units);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (units)
            random_unit();
        wait_quiet();
    endtask

    initial
    begin
        rx_raw_count = 0;
        rx_raw_ovf = 1'b0;
        rx_block_left = 0;
        rx_prev_full = 1'b0;
        rx_dec_err = 1'b0;
        rx_dec_count = 0;
        cnt_good = '0;
        cnt_bad = '0;
        cnt_crc = '0;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads before any frame, empty frame, extremes, each bad kind.
        push_read(7'd0);
        push_read(7'd127);
        push_line(8'h00);
        send_frame(FR_GOOD, 0, 0);
        push_read(7'd0);
        send_frame(FR_GOOD, 120, 0);
        push_read(7'd0);
        push_read(7'd119);
        push_read(7'd120);
        push_read(7'd127);
        send_frame(FR_GOOD, 8, 60);
        send_frame(FR_CRC, 3, 20);
        send_frame(FR_TRUNC, 2, 0);
        send_frame(FR_SHORT, 0, 0);
        send_frame(FR_RAW_OVF, 0, 0);
        push_read(7'd1);
        push_line(8'h00);
        push_line(8'h00);
        send_frame(FR_GOOD, 5, 100);
        push_read(7'd4);
        wait_quiet();

        run_phase(0, 0, 7);
        run_phase(64, 0, 7);
        run_phase(0, 64, 7);
        run_phase(23, 23, 7);
        hold_request = 1;
        run_phase(0, 0, 5);

        repeat (DRAIN)
            @(posedge clk);
        $display("Sent %0d words; checked %0d good, %0d bad, %0d crc-error frames, %0d reads.",
                 words_sent, frames_good, frames_bad, frames_crc, reads_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/ccfr_pkg.sv
sv/ccfr_ram.sv
sv/ccfr_front.sv
sv/ccfr_queue.sv
sv/ccfr_back.sv
sv/cobs_crc_frame_receiver_core.sv
sv/ccfr_checker.sv
bench/tb.sv
